### rtl/plps_pkg.sv
// ----------------------------------------------------------------------------
// plps_pkg
// Shared widths, register indexes, beat types and the saturation helper of
// the PID loop plant simulator.
// ----------------------------------------------------------------------------
`default_nettype none

package plps_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 1024;
  localparam int unsigned DATA_WIDTH_DEF    = 32;

  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned RATE_W    = 25;
  localparam int unsigned DELAY_W   = 10;
  localparam int unsigned TICK_W    = 20;
  localparam int unsigned CRIT_W    = 31;
  localparam int unsigned MUL_W     = 33;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE1_RATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE1_DRIVE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE2_RATE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEPS  = 3'd7;

  localparam logic [VAL_W-1:0]  PROP_GAIN_RST = 32'h0100_0000;
  localparam logic [RATE_W-1:0] STEP_SIZE_RST = 25'd167772;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [CRIT_W-1:0] CRIT_MAX = '1;

  typedef struct packed {
    logic last_tick;
  } in_beat_t;

  typedef struct packed {
    logic [TICK_W-1:0]       tick_index;
    logic signed [VAL_W-1:0] loop_error;
    logic signed [VAL_W-1:0] drive;
    logic signed [VAL_W-1:0] plant_output;
    logic [CRIT_W-1:0]       criterion;
    logic                    run_end;
  } out_beat_t;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  // Clamp a wide signed value to the signed range of w bits.
  function automatic logic signed [VAL_W-1:0] sat(input logic signed [ACC_W-1:0] v,
                                                  input int unsigned w);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] r;
    hi = (ACC_W'(1) <<< (w - 1)) - ACC_W'(1);
    lo = ~hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/plps_stream_if.sv
// ----------------------------------------------------------------------------
// plps_stream_if
// Valid/ready channel carrying one beat of a packed payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface plps_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

### rtl/plps_mul_unit.sv
// ----------------------------------------------------------------------------
// plps_mul_unit
// Shared signed Q8.24 multiplier with round-half-up and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plps_mul_unit (
  input  logic                                  clk_i,
  input  plps_pkg::mul_req_t                    req_i,
  output logic signed [plps_pkg::ACC_W-1:0]     prod_o
);

  localparam int unsigned MUL_W  = plps_pkg::MUL_W;
  localparam int unsigned ACC_W  = plps_pkg::ACC_W;
  localparam int unsigned FRAC   = plps_pkg::FRAC_BITS;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (FRAC - 1);

  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic signed [PROD_W-1:0] full;
  logic signed [PROD_W-1:0] rounded;
  logic signed [ACC_W-1:0]  prod_d;
  logic signed [ACC_W-1:0]  prod_q;

  assign op_a    = req_i.a;
  assign op_b    = req_i.b;
  assign full    = PROD_W'(op_a) * PROD_W'(op_b);
  assign rounded = full + HALF_LSB;
  // Dropping the fraction bits of a signed word is a floor shift.
  assign prod_d  = ACC_W'($signed(rounded[PROD_W-1:FRAC]));

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### rtl/pid_loop_plant_simulator.sv
// ----------------------------------------------------------------------------
// pid_loop_plant_simulator
// Closed-loop unit-step simulation of a PID controller driving two RK4 lags
// and a dead-time line, one tick per input beat, in signed Q8.24.
// ----------------------------------------------------------------------------
// Each input beat advances the simulation by one tick and yields exactly one
// output beat with the tick index, the error, the PID drive, the delayed
// plant output and the running absolute-error criterion. Every product goes
// through one shared 33x33 multiplier, so the 15 multiplies of the criterion,
// the PID law and the two RK4 steps run one after another, and each RK4 step
// ends in a division by six that is done a byte per cycle. The input is not
// ready while a tick is in work; a finished beat waits in the output
// register, and the next tick may already start. The dead-time history is a
// single-port memory of HISTORY_DEPTH words with no clearing pass: entries
// only feed the output once they were written in the current run. The
// configuration is to be written through the plain write port while the
// block is idle; the block itself does not enforce this. A beat with
// last_tick set closes the run and clears the run state afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_loop_plant_simulator #(
  parameter int unsigned HISTORY_DEPTH = plps_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH    = plps_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [plps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [plps_pkg::VAL_W-1:0]          cfg_data_i,
  plps_stream_if.sink                         in_ch,
  plps_stream_if.source                       out_ch
);

  localparam int unsigned VAL_W   = plps_pkg::VAL_W;
  localparam int unsigned RATE_W  = plps_pkg::RATE_W;
  localparam int unsigned DELAY_W = plps_pkg::DELAY_W;
  localparam int unsigned TICK_W  = plps_pkg::TICK_W;
  localparam int unsigned CRIT_W  = plps_pkg::CRIT_W;
  localparam int unsigned MUL_W   = plps_pkg::MUL_W;
  localparam int unsigned ACC_W   = plps_pkg::ACC_W;

  // Saturation width of the loop values: error, integral, drive, slopes, lags.
  localparam int unsigned SAT_W  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int unsigned AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned NS_MAX = HISTORY_DEPTH - 1;

  // RK4 weighted sum is held in 36 bits; the byte-serial divider works on 5 bytes.
  localparam int unsigned KS_W      = 36;
  localparam int unsigned DQ_W      = 40;
  localparam int unsigned DIV_STEPS = DQ_W / 8;

  localparam logic signed [ACC_W-1:0] ONE_Q    = ACC_W'(1) <<< plps_pkg::FRAC_BITS;
  localparam logic signed [ACC_W-1:0] CRIT_TOP = $signed(ACC_W'(plps_pkg::CRIT_MAX));

  // Sequencer states.
  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_ERR      = 5'd1;
  localparam logic [4:0] ST_M_ABS    = 5'd2;
  localparam logic [4:0] ST_M_INT    = 5'd3;
  localparam logic [4:0] ST_M_P      = 5'd4;
  localparam logic [4:0] ST_M_I      = 5'd5;
  localparam logic [4:0] ST_M_D      = 5'd6;
  localparam logic [4:0] ST_DRV      = 5'd7;
  localparam logic [4:0] ST_L_FORCE  = 5'd8;
  localparam logic [4:0] ST_L_MUL    = 5'd9;
  localparam logic [4:0] ST_L_K      = 5'd10;
  localparam logic [4:0] ST_L_ARG    = 5'd11;
  localparam logic [4:0] ST_DIV_PREP = 5'd12;
  localparam logic [4:0] ST_DIV_STEP = 5'd13;
  localparam logic [4:0] ST_DIV_DONE = 5'd14;
  localparam logic [4:0] ST_LAG_UPD  = 5'd15;
  localparam logic [4:0] ST_H_WR     = 5'd16;
  localparam logic [4:0] ST_H_RD     = 5'd17;
  localparam logic [4:0] ST_FIN      = 5'd18;

  // Configuration registers.
  logic signed [VAL_W-1:0] prop_q;
  logic signed [VAL_W-1:0] int_q;
  logic signed [VAL_W-1:0] deriv_q;
  logic [RATE_W-1:0]       step_q;
  logic [RATE_W-1:0]       s1rate_q;
  logic signed [VAL_W-1:0] s1drive_q;
  logic [RATE_W-1:0]       s2rate_q;
  logic [DELAY_W-1:0]      delay_q;

  // Run state.
  logic signed [VAL_W-1:0] integ_q;
  logic signed [VAL_W-1:0] prev_q;
  logic signed [VAL_W-1:0] lag1_q;
  logic signed [VAL_W-1:0] lag2_q;
  logic signed [VAL_W-1:0] dly_q;
  logic [CRIT_W-1:0]       crit_q;
  logic [TICK_W-1:0]       tick_q;
  logic [AW-1:0]           wp_q;

  // Sequencer control.
  logic [4:0] state_q;
  logic [4:0] state_d;
  logic       last_q;
  logic       lag_sel_q;
  logic [1:0] kidx_q;
  logic [2:0] dcnt_q;
  logic       out_valid_q;

  // Datapath registers.
  logic signed [VAL_W-1:0] err_q;
  logic signed [VAL_W-1:0] diff_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [VAL_W-1:0] drv_q;
  logic signed [ACC_W-1:0] force_q;
  logic signed [VAL_W-1:0] k_q;
  logic signed [KS_W-1:0]  ksum_q;
  logic signed [VAL_W-1:0] arg_q;
  logic                    neg_q;
  logic [DQ_W-1:0]         dq_q;
  logic [1:0]              rem_q;
  logic [VAL_W-1:0]        rd_q;
  plps_pkg::out_beat_t     out_q;

  logic [VAL_W-1:0] hist_mem [HISTORY_DEPTH];

  // Shared multiplier.
  plps_pkg::mul_req_t      mul_req;
  logic signed [ACC_W-1:0] p_q;

  plps_mul_unit u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (p_q)
  );

  // The lag being stepped: the first one is driven by the PID output, the
  // second one by the new value of the first.
  logic signed [VAL_W-1:0] z_cur;
  logic signed [VAL_W-1:0] x_cur;
  logic [RATE_W-1:0]       rate_cur;
  logic signed [MUL_W-1:0] gain_cur;

  assign z_cur    = lag_sel_q ? lag2_q : lag1_q;
  assign x_cur    = lag_sel_q ? lag1_q : drv_q;
  assign rate_cur = lag_sel_q ? s2rate_q : s1rate_q;
  assign gain_cur = lag_sel_q ? $signed(MUL_W'(s2rate_q)) : MUL_W'(s1drive_q);

  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = '0;
    mul_req.b  = '0;
    case (state_q)
      ST_M_ABS: begin
        mul_req.en = 1'b1;
        mul_req.a  = err_q[VAL_W-1] ? -MUL_W'(err_q) : MUL_W'(err_q);
        mul_req.b  = $signed(MUL_W'(step_q));
      end
      ST_M_INT: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(err_q);
        mul_req.b  = $signed(MUL_W'(step_q));
      end
      ST_M_P: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(prop_q);
        mul_req.b  = MUL_W'(err_q);
      end
      ST_M_I: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(int_q);
        mul_req.b  = MUL_W'(integ_q);
      end
      ST_M_D: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(deriv_q);
        mul_req.b  = MUL_W'(diff_q);
      end
      ST_L_FORCE: begin
        mul_req.en = 1'b1;
        mul_req.a  = gain_cur;
        mul_req.b  = MUL_W'(x_cur);
      end
      ST_L_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = $signed(MUL_W'(rate_cur));
        mul_req.b  = MUL_W'(arg_q);
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  // Error, criterion and integral arithmetic.
  logic signed [VAL_W-1:0] err_d;
  logic signed [ACC_W-1:0] crit_sum;
  logic [CRIT_W-1:0]       crit_d;

  assign err_d    = plps_pkg::sat(ONE_Q - ACC_W'(dly_q), SAT_W);
  assign crit_sum = $signed(ACC_W'(crit_q)) + p_q;

  always_comb begin
    if (crit_sum > CRIT_TOP) begin
      crit_d = plps_pkg::CRIT_MAX;
    end else if (crit_sum < 0) begin
      crit_d = '0;
    end else begin
      crit_d = crit_sum[CRIT_W-1:0];
    end
  end

  // RK4 helpers: the next slope, the next evaluation point and the weighted
  // slope sum k1 + 2*k2 + 2*k3 + k4.
  logic signed [VAL_W-1:0] k_d;
  logic signed [VAL_W-1:0] arg_d;
  logic signed [KS_W-1:0]  ksum_d;

  assign k_d = plps_pkg::sat(force_q - p_q, SAT_W);

  always_comb begin
    if (kidx_q == 2'd2) begin
      arg_d = plps_pkg::sat(ACC_W'(z_cur) + ACC_W'(k_q), SAT_W);
    end else begin
      arg_d = plps_pkg::sat(ACC_W'(z_cur) + ACC_W'(k_q >>> 1), SAT_W);
    end
    case (kidx_q)
      2'd0:    ksum_d = KS_W'(k_q);
      2'd3:    ksum_d = ksum_q + KS_W'(k_q);
      default: ksum_d = ksum_q + (KS_W'(k_q) <<< 1);
    endcase
  end

  // Division of the slope sum by six, rounded half away from zero:
  // floor((|s| + 3) / 6) = floor(floor((|s| + 3) / 2) / 3), the division by
  // three taken one byte per cycle with a small reciprocal multiply.
  logic [KS_W-1:0] ks_mag;
  logic [KS_W:0]   ks_plus3;
  logic [9:0]      dv_t;
  logic [19:0]     dv_m;
  logic [7:0]      dv_q;
  logic [9:0]      dv_r;

  assign ks_mag   = ksum_q[KS_W-1] ? -ksum_q : ksum_q;
  assign ks_plus3 = {1'b0, ks_mag} + (KS_W+1)'(3);
  assign dv_t     = {rem_q, dq_q[DQ_W-1 -: 8]};
  assign dv_m     = {10'b0, dv_t} * 20'd683;
  assign dv_q     = dv_m[18:11];
  assign dv_r     = dv_t - (10'(dv_q) * 10'd3);

  logic signed [ACC_W-1:0] quo_ext;
  logic signed [VAL_W-1:0] inc_d;
  logic signed [VAL_W-1:0] lag_new;

  assign quo_ext = $signed(ACC_W'(dq_q[32:0]));
  assign inc_d   = plps_pkg::sat(neg_q ? -quo_ext : quo_ext, SAT_W);
  assign lag_new = plps_pkg::sat(ACC_W'(z_cur) + ACC_W'(k_q), SAT_W);

  // Dead-time line addressing.
  logic [AW-1:0]   ns;
  logic [AW:0]     rsum;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   wp_next;
  logic            dly_sel;
  logic [VAL_W-1:0] dly_new;
  logic [TICK_W-1:0] tick_next;

  always_comb begin
    if (32'(delay_q) > NS_MAX) begin
      ns = AW'(NS_MAX);
    end else begin
      ns = AW'(delay_q);
    end
    if (wp_q >= ns) begin
      rsum = {1'b0, wp_q} - {1'b0, ns};
    end else begin
      rsum = {1'b0, wp_q} + (AW+1)'(HISTORY_DEPTH) - {1'b0, ns};
    end
  end

  assign raddr     = rsum[AW-1:0];
  assign wp_next   = (32'(wp_q) == NS_MAX) ? '0 : wp_q + AW'(1);
  assign dly_sel   = 32'(tick_q) > 32'(ns);
  assign dly_new   = dly_sel ? rd_q : '0;
  assign tick_next = (tick_q == plps_pkg::TICK_MAX) ? tick_q : tick_q + TICK_W'(1);

  logic in_acc;
  logic fin_go;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid && (state_q == ST_IDLE);
  // The result is moved into the output register once it is free.
  assign fin_go      = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_ch.valid) state_d = ST_ERR;
      ST_ERR:      state_d = ST_M_ABS;
      ST_M_ABS:    state_d = ST_M_INT;
      ST_M_INT:    state_d = ST_M_P;
      ST_M_P:      state_d = ST_M_I;
      ST_M_I:      state_d = ST_M_D;
      ST_M_D:      state_d = ST_DRV;
      ST_DRV:      state_d = ST_L_FORCE;
      ST_L_FORCE:  state_d = ST_L_MUL;
      ST_L_MUL:    state_d = ST_L_K;
      ST_L_K:      state_d = ST_L_ARG;
      ST_L_ARG:    state_d = (kidx_q == 2'd3) ? ST_DIV_PREP : ST_L_MUL;
      ST_DIV_PREP: state_d = ST_DIV_STEP;
      ST_DIV_STEP: if (dcnt_q == 3'(DIV_STEPS - 1)) state_d = ST_DIV_DONE;
      ST_DIV_DONE: state_d = ST_LAG_UPD;
      ST_LAG_UPD:  state_d = lag_sel_q ? ST_H_WR : ST_L_FORCE;
      ST_H_WR:     state_d = ST_H_RD;
      ST_H_RD:     state_d = ST_FIN;
      ST_FIN:      if (fin_go) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control state and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      lag_sel_q   <= 1'b0;
      kidx_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        last_q <= in_ch.payload.last_tick;
      end
      if (state_q == ST_DRV) begin
        lag_sel_q <= 1'b0;
      end else if (state_q == ST_LAG_UPD) begin
        lag_sel_q <= 1'b1;
      end
      if (state_q == ST_L_FORCE) begin
        kidx_q <= '0;
      end else if (state_q == ST_L_ARG) begin
        kidx_q <= kidx_q + 2'd1;
      end
      if (state_q == ST_DIV_PREP) begin
        dcnt_q <= '0;
      end else if (state_q == ST_DIV_STEP) begin
        dcnt_q <= dcnt_q + 3'd1;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q    <= plps_pkg::PROP_GAIN_RST;
      int_q     <= '0;
      deriv_q   <= '0;
      step_q    <= plps_pkg::STEP_SIZE_RST;
      s1rate_q  <= '0;
      s1drive_q <= '0;
      s2rate_q  <= '0;
      delay_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plps_pkg::REG_PROP_GAIN:    prop_q    <= cfg_data_i;
        plps_pkg::REG_INT_GAIN:     int_q     <= cfg_data_i;
        plps_pkg::REG_DERIV_GAIN:   deriv_q   <= cfg_data_i;
        plps_pkg::REG_STEP_SIZE:    step_q    <= cfg_data_i[RATE_W-1:0];
        plps_pkg::REG_STAGE1_RATE:  s1rate_q  <= cfg_data_i[RATE_W-1:0];
        plps_pkg::REG_STAGE1_DRIVE: s1drive_q <= cfg_data_i;
        plps_pkg::REG_STAGE2_RATE:  s2rate_q  <= cfg_data_i[RATE_W-1:0];
        plps_pkg::REG_DELAY_STEPS:  delay_q   <= cfg_data_i[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Run state. A closing tick clears everything except the history contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
      lag1_q  <= '0;
      lag2_q  <= '0;
      dly_q   <= '0;
      crit_q  <= '0;
      tick_q  <= '0;
      wp_q    <= '0;
    end else begin
      if (state_q == ST_M_INT) begin
        crit_q <= crit_d;
      end
      if (state_q == ST_M_P) begin
        integ_q <= plps_pkg::sat(ACC_W'(integ_q) + p_q, SAT_W);
      end
      if (state_q == ST_LAG_UPD) begin
        if (lag_sel_q) begin
          lag2_q <= lag_new;
        end else begin
          lag1_q <= lag_new;
        end
      end
      if (fin_go) begin
        if (last_q) begin
          integ_q <= '0;
          prev_q  <= '0;
          lag1_q  <= '0;
          lag2_q  <= '0;
          dly_q   <= '0;
          crit_q  <= '0;
          tick_q  <= '0;
          wp_q    <= '0;
        end else begin
          dly_q  <= dly_new;
          prev_q <= err_q;
          tick_q <= tick_next;
          wp_q   <= wp_next;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_ERR: begin
        err_q <= err_d;
      end
      ST_M_P: begin
        diff_q <= plps_pkg::sat(ACC_W'(err_q) - ACC_W'(prev_q), SAT_W);
      end
      ST_M_I: begin
        acc_q <= p_q;
      end
      ST_M_D: begin
        acc_q <= acc_q + p_q;
      end
      ST_DRV: begin
        drv_q <= plps_pkg::sat(acc_q + p_q, SAT_W);
      end
      ST_L_FORCE: begin
        arg_q <= z_cur;
      end
      ST_L_MUL: begin
        if (kidx_q == 2'd0) begin
          force_q <= p_q;
        end
      end
      ST_L_K: begin
        k_q <= k_d;
      end
      ST_L_ARG: begin
        ksum_q <= ksum_d;
        arg_q  <= arg_d;
      end
      ST_DIV_PREP: begin
        neg_q <= ksum_q[KS_W-1];
        dq_q  <= DQ_W'(ks_plus3[KS_W:1]);
        rem_q <= '0;
      end
      ST_DIV_STEP: begin
        dq_q  <= {dq_q[DQ_W-9:0], dv_q};
        rem_q <= dv_r[1:0];
      end
      ST_DIV_DONE: begin
        k_q <= inc_d;
      end
      default: begin
      end
    endcase
    if (fin_go) begin
      out_q.tick_index   <= tick_q;
      out_q.loop_error   <= err_q;
      out_q.drive        <= drv_q;
      out_q.plant_output <= dly_new;
      out_q.criterion    <= crit_q;
      out_q.run_end      <= last_q;
    end
  end

  // Dead-time history: one write of the second lag per tick, then a read of
  // the entry written the dead time earlier (the new entry at zero delay).
  always_ff @(posedge clk_i) begin
    if (state_q == ST_H_WR) begin
      hist_mem[wp_q] <= lag2_q;
    end
    if (state_q == ST_H_RD) begin
      rd_q <= hist_mem[raddr];
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_q;

endmodule

`default_nettype wire

### rtl/plps_checker.sv
// ----------------------------------------------------------------------------
// plps_checker
// Port-level assertions of the PID loop plant simulator, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module plps_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  plps_pkg::out_beat_t out_beat_i
);

  // A result beat that is not taken stays offered.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // A stalled result beat keeps its contents.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_beat_i))
    else $error("output beat changed while stalled");

  // The block works on one tick at a time.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted again while a tick is in work");

  // The first tick of a run always lies inside the dead time.
  a_first_tick_dead : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_beat_i.tick_index == '0)) |-> (out_beat_i.plant_output == '0))
    else $error("plant output nonzero on the first tick of a run");

endmodule

bind pid_loop_plant_simulator plps_checker u_plps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_beat_i  (out_ch.payload)
);

`default_nettype wire

### dv/pid_loop_plant_simulator_test.sv
// ----------------------------------------------------------------------------
// pid_loop_plant_simulator_test
// Self-checking testbench of the PID loop plant simulator. Tick beats are
// pushed through the input channel with random idling. Every accepted tick is
// run through a bit-exact software copy of the control loop and the plant.
// Every output beat is compared field by field with the oldest predicted
// beat. Register settings change only while the block is idle.
// ----------------------------------------------------------------------------
module pid_loop_plant_simulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import plps_pkg::*;

  // Fixed-point limits of the Q8.24 datapath and of the running criterion.
  localparam longint Q_MAX      = 64'sd2147483647;
  localparam longint Q_MIN      = -64'sd2147483648;
  localparam longint ONE_Q      = 64'sd16777216;
  localparam longint ROUND_BIT  = 64'sd8388608;
  localparam longint CRIT_TOP   = 64'sd2147483647;
  localparam int     HIST_DEPTH = HISTORY_DEPTH_DEF;
  localparam int unsigned TICK_TOP = 32'd1048575;

  // The settle time at the end is longer than one tick inside the block.
  localparam int SETTLE_CYCLES = 80;

  // A full set of register values, kept at the register widths.
  typedef struct packed {
    logic signed [VAL_W-1:0] kp;
    logic signed [VAL_W-1:0] ki;
    logic signed [VAL_W-1:0] kd;
    logic [RATE_W-1:0]       dt;
    logic [RATE_W-1:0]       s1_rate;
    logic signed [VAL_W-1:0] s1_drive;
    logic [RATE_W-1:0]       s2_rate;
    logic [DELAY_W-1:0]      dead_ticks;
  } loop_cfg_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the registers and of the run state,
  // predicts the beat of every accepted tick and checks the output beats in
  // order against the predictions.
  // --------------------------------------------------------------------------
  class tick_ledger;
    logic signed [VAL_W-1:0] kp, ki, kd, s1_drive;
    logic [RATE_W-1:0]       dt, s1_rate, s2_rate;
    logic [DELAY_W-1:0]      dead_ticks;

    longint      err_integral, prev_err, lag1, lag2, delayed_out, abs_err_sum;
    int unsigned tick_cnt, wr_pos;
    longint      history [HIST_DEPTH];

    out_beat_t   awaited_beats [$];
    int          mismatches;

    function new();
      kp         = PROP_GAIN_RST;
      ki         = '0;
      kd         = '0;
      dt         = STEP_SIZE_RST;
      s1_rate    = '0;
      s1_drive   = '0;
      s2_rate    = '0;
      dead_ticks = '0;
      mismatches = 0;
      foreach (history[i]) history[i] = 0;
      clear_run();
    endfunction

    function void clear_run();
      err_integral = 0;
      prev_err     = 0;
      lag1         = 0;
      lag2         = 0;
      delayed_out  = 0;
      abs_err_sum  = 0;
      tick_cnt     = 0;
      wr_pos       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
      case (idx)
        REG_PROP_GAIN:    kp = data;
        REG_INT_GAIN:     ki = data;
        REG_DERIV_GAIN:   kd = data;
        REG_STEP_SIZE:    dt = data[RATE_W-1:0];
        REG_STAGE1_RATE:  s1_rate = data[RATE_W-1:0];
        REG_STAGE1_DRIVE: s1_drive = data;
        REG_STAGE2_RATE:  s2_rate = data[RATE_W-1:0];
        REG_DELAY_STEPS:  dead_ticks = data[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_q(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    // Q8.24 product, rounded half up.
    function longint fx_mul(longint a, longint b);
      return (a * b + ROUND_BIT) >>> FRAC_BITS;
    endfunction

    // Division by six, rounding to nearest with halves away from zero.
    function longint sixth_rounded(longint v);
      if (v >= 0) return (v + 3) / 6;
      return -((3 - v) / 6);
    endfunction

    // One RK4 step of z' = -rate*z + gain*x, both coefficients prescaled by dt.
    function longint rk4_lag(longint z, longint x, longint rate, longint gain);
      longint drive_term, k1, k2, k3, k4;
      drive_term = fx_mul(gain, x);
      k1 = clamp_q(drive_term - fx_mul(rate, z));
      k2 = clamp_q(drive_term - fx_mul(rate, clamp_q(z + (k1 >>> 1))));
      k3 = clamp_q(drive_term - fx_mul(rate, clamp_q(z + (k2 >>> 1))));
      k4 = clamp_q(drive_term - fx_mul(rate, clamp_q(z + k3)));
      return clamp_q(z + clamp_q(sixth_rounded(k1 + 2 * k2 + 2 * k3 + k4)));
    endfunction

    // Advances the loop by one tick and returns the beat the block must emit.
    function out_beat_t simulate_tick(bit last);
      out_beat_t   beat;
      int unsigned idx, span;
      longint      err, mag, diff, drv;
      idx  = tick_cnt;
      span = (dead_ticks > HIST_DEPTH - 1) ? HIST_DEPTH - 1 : dead_ticks;

      err = clamp_q(ONE_Q - delayed_out);
      mag = (err < 0) ? -err : err;
      abs_err_sum = abs_err_sum + fx_mul(mag, longint'(dt));
      if (abs_err_sum > CRIT_TOP) abs_err_sum = CRIT_TOP;
      if (abs_err_sum < 0) abs_err_sum = 0;
      err_integral = clamp_q(err_integral + fx_mul(err, longint'(dt)));

      diff = clamp_q(err - prev_err);
      drv  = clamp_q(fx_mul(kp, err) + fx_mul(ki, err_integral) + fx_mul(kd, diff));

      lag1 = rk4_lag(lag1, drv, longint'(s1_rate), s1_drive);
      lag2 = rk4_lag(lag2, lag1, longint'(s2_rate), longint'(s2_rate));

      history[wr_pos] = lag2;
      if (idx > span) begin
        delayed_out = history[(wr_pos + HIST_DEPTH - span) % HIST_DEPTH];
      end else begin
        delayed_out = 0;
      end
      wr_pos = (wr_pos + 1) % HIST_DEPTH;

      prev_err = err;
      if (tick_cnt < TICK_TOP) tick_cnt++;

      beat.tick_index   = idx[TICK_W-1:0];
      beat.loop_error   = err[VAL_W-1:0];
      beat.drive        = drv[VAL_W-1:0];
      beat.plant_output = delayed_out[VAL_W-1:0];
      beat.criterion    = abs_err_sum[CRIT_W-1:0];
      beat.run_end      = last;
      if (last) clear_run();
      return beat;
    endfunction

    function void note_tick(bit last);
      awaited_beats.push_back(simulate_tick(last));
    endfunction

    function int pending();
      return awaited_beats.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (awaited_beats.size() == 0) begin
        report($sformatf("output beat with no tick waiting, tick_index %0d",
                         got.tick_index));
        return;
      end
      want = awaited_beats.pop_front();
      if (got.tick_index !== want.tick_index)
        report($sformatf("tick %0d tick_index got %0d", want.tick_index, got.tick_index));
      if (got.loop_error !== want.loop_error)
        report($sformatf("tick %0d loop_error got %h want %h", want.tick_index,
                         got.loop_error, want.loop_error));
      if (got.drive !== want.drive)
        report($sformatf("tick %0d drive got %h want %h", want.tick_index,
                         got.drive, want.drive));
      if (got.plant_output !== want.plant_output)
        report($sformatf("tick %0d plant_output got %h want %h", want.tick_index,
                         got.plant_output, want.plant_output));
      if (got.criterion !== want.criterion)
        report($sformatf("tick %0d criterion got %h want %h", want.tick_index,
                         got.criterion, want.criterion));
      if (got.run_end !== want.run_end)
        report($sformatf("tick %0d run_end got %b want %b", want.tick_index,
                         got.run_end, want.run_end));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, configuration port and the two channels.
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [VAL_W-1:0]     cfg_data_i;

  plps_stream_if #(.payload_t(in_beat_t))  in_ch ();
  plps_stream_if #(.payload_t(out_beat_t)) out_ch ();

  pid_loop_plant_simulator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tick_ledger ledger = new();

  // Idle odds in percent for the sender and the receiver; the main sequence
  // changes them between phases.
  int tx_idle_pct = 26;
  int rx_idle_pct = 49;
  int rx_hold;

  // --------------------------------------------------------------------------
  // Receiver. Values are read right after the rising edge, i.e. the values
  // that were in effect at the edge, so a handshake seen here is a beat that
  // the block really handed over. Now and then ready drops for a long
  // stretch, often longer than one tick, so that a finished beat has to wait in
  // the output register while the next tick is already being worked on.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    rx_hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        ledger.check_beat(out_ch.payload);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(20, 120);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks.
  // --------------------------------------------------------------------------

  // Writes one register; the write enable is left high so that back-to-back
  // writes keep it up. The caller lowers it after the last write.
  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    ledger.set_reg(idx, data);
  endtask

  task program_regs(loop_cfg_t c);
    write_reg(REG_PROP_GAIN, c.kp);
    write_reg(REG_INT_GAIN, c.ki);
    write_reg(REG_DERIV_GAIN, c.kd);
    write_reg(REG_STEP_SIZE, VAL_W'(c.dt));
    write_reg(REG_STAGE1_RATE, VAL_W'(c.s1_rate));
    write_reg(REG_STAGE1_DRIVE, c.s1_drive);
    write_reg(REG_STAGE2_RATE, VAL_W'(c.s2_rate));
    write_reg(REG_DELAY_STEPS, VAL_W'(c.dead_ticks));
    cfg_we_i <= 1'b0;
  endtask

  // Offers one tick beat and returns once it is taken. A random gap may come
  // first, long enough to land anywhere in the block's tick. When no gap is
  // taken, valid simply stays high.
  task send_tick(bit last);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{last_tick: last};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    ledger.note_tick(last);
  endtask

  // Sends a burst of ticks. last_odds of zero means last_tick is never set
  // at random; close marks the final tick of the burst as the end of a run.
  task run_ticks(int count, int last_odds, bit close);
    bit last;
    for (int i = 0; i < count; i++) begin
      last = (close && i == count - 1) ||
             (last_odds > 0 && $urandom_range(0, last_odds - 1) == 0);
      send_tick(last);
    end
  endtask

  // Holds the sender off until every predicted beat has come back, so that
  // the block is idle and registers may be rewritten.
  task drain();
    in_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Random register values: mostly a well-behaved loop with moderate gains,
  // rates and dead time, so that the plant output actually moves, with the
  // range extremes and fully random values mixed in.
  // --------------------------------------------------------------------------
  function automatic logic signed [VAL_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return int'($urandom_range(0, 32'd134217728)) - 67108864;
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 25'd16777216;
      2: return RATE_W'($urandom_range(0, 32'd16777216));
      default: return RATE_W'($urandom_range(0, 32'd2097152));
    endcase
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return DELAY_W'($urandom_range(0, 1023));
      default: return DELAY_W'($urandom_range(0, 12));
    endcase
  endfunction

  function automatic loop_cfg_t rand_cfg();
    loop_cfg_t c;
    c.kp         = pick_gain();
    c.ki         = pick_gain();
    c.kd         = pick_gain();
    c.dt         = pick_rate();
    c.s1_rate    = pick_rate();
    c.s1_drive   = pick_gain();
    c.s2_rate    = pick_rate();
    c.dead_ticks = pick_delay();
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  loop_cfg_t cfg;

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_PROP_GAIN;
    cfg_data_i    <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the registers: proportional gain of one, no plant
    // dynamics, so the drive stays at one and only the criterion grows.
    run_ticks(2, 0, 1'b1);

    // A sensible loop with a dead time of three ticks: the plant output must
    // read zero until the tick index passes the delay.
    drain();
    cfg = '{kp: 32'sh0200_0000, ki: 32'sh0080_0000, kd: 32'sh0040_0000,
            dt: 25'd167772, s1_rate: 25'd1677722, s1_drive: 32'sd3355443,
            s2_rate: 25'd838861, dead_ticks: 10'd3};
    program_regs(cfg);
    run_ticks(8, 0, 1'b1);

    // Same loop, no dead time: past tick 0 the output is that tick's second lag.
    drain();
    cfg.dead_ticks = '0;
    program_regs(cfg);
    run_ticks(3, 0, 1'b1);

    // Largest gains but for the most negative derivative gain, full rates:
    // drive, lags and error saturate, and the criterion runs into its ceiling.
    drain();
    cfg = '{kp: 32'sh7FFF_FFFF, ki: 32'sh7FFF_FFFF, kd: 32'sh8000_0000,
            dt: 25'd16777216, s1_rate: 25'd16777216, s1_drive: 32'sh7FFF_FFFF,
            s2_rate: 25'd16777216, dead_ticks: 10'd0};
    program_regs(cfg);
    run_ticks(5, 0, 1'b1);

    // Most negative gains but the largest derivative gain, one-tick dead time.
    drain();
    cfg = '{kp: 32'sh8000_0000, ki: 32'sh8000_0000, kd: 32'sh7FFF_FFFF,
            dt: 25'd16777216, s1_rate: 25'd0, s1_drive: 32'sh8000_0000,
            s2_rate: 25'd16777216, dead_ticks: 10'd1};
    program_regs(cfg);
    run_ticks(4, 0, 1'b1);

    // Everything at zero and the longest dead time.
    drain();
    cfg = '0;
    cfg.dead_ticks = '1;
    program_regs(cfg);
    run_ticks(2, 0, 1'b1);

    // Random phases. Phases 0-2 use the first idle mix, 3-5 the reverse and
    // 6-8 run without idling. Runs end at random, so some of them span a
    // register change. Phase 7 holds the longest dead time over one run of
    // more than a full history, which makes the write position wrap and the
    // delayed output come from the far end of the line.
    for (int p = 0; p < 9; p++) begin
      drain();
      if (p < 3) begin
        tx_idle_pct = 26;
        rx_idle_pct = 49;
      end else if (p < 6) begin
        tx_idle_pct = 49;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      cfg = rand_cfg();
      if (p == 7) begin
        cfg.dead_ticks = '1;
        program_regs(cfg);
        run_ticks(HIST_DEPTH + 16, 0, 1'b1);
      end else begin
        program_regs(cfg);
        run_ticks(60, 24, 1'b0);
      end
    end

    // Wait for the last beats, then give the block time to show any stray
    // beat it should not produce.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (ledger.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog. A correct run takes a few milliseconds at most even with the
  // worst idling; this ends a hung run.
  initial begin
    #(20ms);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
rtl/plps_pkg.sv
rtl/plps_stream_if.sv
rtl/plps_mul_unit.sv
rtl/pid_loop_plant_simulator.sv
rtl/plps_checker.sv
dv/pid_loop_plant_simulator_test.sv
